[hw/rtl/nsw_pkg.sv]
package nsw_pkg;

  // Decimal digits kept for a magnitude of up to 2^31.
  localparam int NSW_DIGITS = 10;
  localparam int NSW_BCD_W = 4 * NSW_DIGITS;
  localparam int NSW_MAG_W = 32;
  // Two binary bits are folded into the BCD register per conversion step.
  localparam int NSW_BITS_PER_STEP = 2;
  localparam int NSW_CONV_STEPS = NSW_MAG_W / NSW_BITS_PER_STEP;
  localparam int NSW_CNT_W = $clog2(NSW_CONV_STEPS);

  localparam logic [NSW_MAG_W-1:0] NSW_BILLION = 32'd1000000000;
  localparam logic [NSW_MAG_W-1:0] NSW_INT_MAX = 32'h7FFF_FFFF;
  localparam logic [NSW_MAG_W-1:0] NSW_INT_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    TK_CARD  = 4'd0,
    TK_ORD   = 4'd1,
    TK_MINUS = 4'd2,
    TK_HUND  = 4'd3,
    TK_THOU  = 4'd4,
    TK_MILL  = 4'd5,
    TK_BILL  = 4'd6,
    TK_OHUND = 4'd7,
    TK_OTHOU = 4'd8,
    TK_OMILL = 4'd9,
    TK_OBILL = 4'd10,
    TK_LAST  = 4'd11,
    TK_NONE  = 4'd12,
    TK_ERROR = 4'd13
  } tok_cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MINUS,
    ST_SPEC,
    ST_WORDS,
    ST_FLUSH
  } state_t;

  // Which token slot the datapath evaluates in the current cycle.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MINUS,
    KIND_SPEC,
    KIND_WORD
  } kind_t;

  typedef enum logic [1:0] {
    GRP_BIL,
    GRP_MIL,
    GRP_THO,
    GRP_UNI
  } grp_t;

  typedef enum logic [2:0] {
    SUB_HUNDW,
    SUB_HUND,
    SUB_TENS,
    SUB_ONES,
    SUB_GROUP
  } sub_t;

  typedef struct packed {
    logic  load;
    logic  conv;
    logic  capture;
    logic  flush;
    kind_t kind;
    grp_t  grp;
    sub_t  sub;
  } cmd_t;

  typedef struct packed {
    logic apply;
    logic pend_v;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/number_to_spoken_word_tokens.sv]
// Each token waits in a pending stage until the next token or the final flush, so the
// last token of a number is presented only after the flush step. A new number is
// accepted only when the controller is idle again, after the 16-step binary-to-decimal
// conversion and the walk over 22 token slots. Tokens leave at most one per cycle; a
// stalled output holds the walk.
// Reset: synchronous, active low; it clears the controller and the valid flags.
module number_to_spoken_word_tokens (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_token_class,
  output logic [6:0]         out_word_value,
  output logic               out_last
);

  // The controller accepts one request at a time. After the accept it runs
  // the datapath's double-dabble converter, two magnitude bits a cycle,
  // which leaves ten decimal digits. It then walks the token slots:
  // the minus sign, one slot for the special cases (zero, the cardinal range
  // error, the ordinal largest value), and five slots for each of the billion,
  // million, thousand and unit groups (hundreds word, hundred, tens word,
  // ones or teens word, group name). Each slot either yields a token or is
  // skipped.
  //
  // A yielded token first sits in a pending stage. When the next token
  // arrives, the pending one moves to the output register with last clear;
  // after the final slot the flush step moves it with last set. The output
  // register decouples the walk from the consumer, so the walk stalls only
  // when both stages are full.

  nsw_pkg::cmd_t  cmd;
  nsw_pkg::stat_t stat;

  nsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_class (out_token_class),
    .out_word_value  (out_word_value),
    .out_last        (out_last)
  );

endmodule

[hw/rtl/nsw_ctrl.sv]
module nsw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nsw_pkg::stat_t  stat,
  output nsw_pkg::cmd_t   cmd
);

  nsw_pkg::state_t state_r, state_nxt;
  logic [nsw_pkg::NSW_CNT_W-1:0] cnt_r, cnt_nxt;
  nsw_pkg::grp_t grp_r, grp_nxt;
  nsw_pkg::sub_t sub_r, sub_nxt;
  logic step_go;
  logic speaking;

  // A slot moves on when it has nothing to say or its token can be stored.
  assign step_go = !stat.apply || !stat.pend_v || stat.out_free;
  assign speaking = (state_r == nsw_pkg::ST_MINUS) || (state_r == nsw_pkg::ST_SPEC) ||
                    (state_r == nsw_pkg::ST_WORDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nsw_pkg::ST_IDLE;
      cnt_r   <= '0;
      grp_r   <= nsw_pkg::GRP_BIL;
      sub_r   <= nsw_pkg::SUB_HUNDW;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      grp_r   <= grp_nxt;
      sub_r   <= sub_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    grp_nxt   = grp_r;
    sub_nxt   = sub_r;
    unique case (state_r)
      nsw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nsw_pkg::ST_CONV;
          cnt_nxt   = '0;
        end
      end
      nsw_pkg::ST_CONV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == nsw_pkg::NSW_CNT_W'(nsw_pkg::NSW_CONV_STEPS - 1)) begin
          state_nxt = nsw_pkg::ST_MINUS;
        end
      end
      nsw_pkg::ST_MINUS: begin
        if (step_go) begin
          state_nxt = nsw_pkg::ST_SPEC;
        end
      end
      nsw_pkg::ST_SPEC: begin
        if (step_go) begin
          state_nxt = nsw_pkg::ST_WORDS;
          grp_nxt   = nsw_pkg::GRP_BIL;
          sub_nxt   = nsw_pkg::SUB_HUNDW;
        end
      end
      nsw_pkg::ST_WORDS: begin
        if (step_go) begin
          if (sub_r == nsw_pkg::SUB_GROUP) begin
            sub_nxt = nsw_pkg::SUB_HUNDW;
            if (grp_r == nsw_pkg::GRP_UNI) begin
              state_nxt = nsw_pkg::ST_FLUSH;
            end else begin
              grp_nxt = nsw_pkg::grp_t'(grp_r + 2'd1);
            end
          end else begin
            sub_nxt = nsw_pkg::sub_t'(sub_r + 3'd1);
          end
        end
      end
      nsw_pkg::ST_FLUSH: begin
        if (!stat.pend_v || stat.out_free) begin
          state_nxt = nsw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nsw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == nsw_pkg::ST_IDLE);
    cmd.load    = (state_r == nsw_pkg::ST_IDLE) && in_valid;
    cmd.conv    = (state_r == nsw_pkg::ST_CONV);
    cmd.capture = speaking && stat.apply && (!stat.pend_v || stat.out_free);
    cmd.flush   = (state_r == nsw_pkg::ST_FLUSH) && stat.pend_v && stat.out_free;
    cmd.grp     = grp_r;
    cmd.sub     = sub_r;
    unique case (state_r)
      nsw_pkg::ST_MINUS: cmd.kind = nsw_pkg::KIND_MINUS;
      nsw_pkg::ST_SPEC:  cmd.kind = nsw_pkg::KIND_SPEC;
      nsw_pkg::ST_WORDS: cmd.kind = nsw_pkg::KIND_WORD;
      default:           cmd.kind = nsw_pkg::KIND_NONE;
    endcase
  end

endmodule

[hw/rtl/nsw_dp.sv]
module nsw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_op,
  input  logic signed [31:0]  in_value,
  input  nsw_pkg::cmd_t       cmd,
  output nsw_pkg::stat_t      stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_token_class,
  output logic [6:0]          out_word_value,
  output logic                out_last
);

  logic                               op_r;
  logic [nsw_pkg::NSW_MAG_W-1:0]      u_r;
  logic [nsw_pkg::NSW_MAG_W-1:0]      mag_r;
  logic [nsw_pkg::NSW_MAG_W-1:0]      sh_r;
  logic [nsw_pkg::NSW_BCD_W-1:0]      bcd_r;
  logic [nsw_pkg::NSW_MAG_W-1:0]      u_in;
  logic [nsw_pkg::NSW_MAG_W-1:0]      mag_in;

  nsw_pkg::tok_cls_t pend_cls_r, out_cls_r, cur_cls;
  logic [6:0] pend_word_r, out_word_r, cur_word;
  logic pend_v_r, out_valid_r, out_last_r;
  logic cur_apply;
  logic out_free, push;

  logic is_zero, is_min, is_big, is_max, words_on;
  logic [3:0] h, t, o;
  logic nz_b, nz_m, nz_t, nz_u, nz_g, rest_nz, hi_before;
  logic is_u, is_t, t_one, gate;
  logic [6:0] tens7, rem7;
  logic bcd_ok;

  function automatic logic [nsw_pkg::NSW_BCD_W-1:0] dd_step(
    input logic [nsw_pkg::NSW_BCD_W-1:0] b,
    input logic                          bit_in
  );
    logic [nsw_pkg::NSW_BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < nsw_pkg::NSW_DIGITS; i++) begin
      if (a[4*i +: 4] > 4'd4) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[nsw_pkg::NSW_BCD_W-2:0], bit_in};
  endfunction

  assign u_in   = in_value;
  assign mag_in = u_in[31] ? (~u_in + 32'd1) : u_in;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      u_r   <= u_in;
      mag_r <= mag_in;
      sh_r  <= mag_in;
      bcd_r <= '0;
    end else if (cmd.conv) begin
      bcd_r <= dd_step(dd_step(bcd_r, sh_r[31]), sh_r[30]);
      sh_r  <= {sh_r[29:0], 2'b00};
    end
  end

  // Special cases of the whole number.
  assign is_zero  = (u_r == '0);
  assign is_min   = (u_r == nsw_pkg::NSW_INT_MIN);
  assign is_big   = (mag_r >= nsw_pkg::NSW_BILLION);
  assign is_max   = (mag_r == nsw_pkg::NSW_INT_MAX);
  assign words_on = !is_zero && !is_min && !(!op_r && is_big) && !(op_r && is_max);

  assign nz_b = (bcd_r[39:36] != 4'd0);
  assign nz_m = (bcd_r[35:24] != 12'd0);
  assign nz_t = (bcd_r[23:12] != 12'd0);
  assign nz_u = (bcd_r[11:0] != 12'd0);

  always_comb begin
    unique case (cmd.grp)
      nsw_pkg::GRP_BIL: begin
        h = 4'd0; t = 4'd0; o = bcd_r[39:36];
        nz_g = nz_b; rest_nz = nz_m || nz_t || nz_u; hi_before = 1'b0;
      end
      nsw_pkg::GRP_MIL: begin
        h = bcd_r[35:32]; t = bcd_r[31:28]; o = bcd_r[27:24];
        nz_g = nz_m; rest_nz = nz_t || nz_u; hi_before = nz_b;
      end
      nsw_pkg::GRP_THO: begin
        h = bcd_r[23:20]; t = bcd_r[19:16]; o = bcd_r[15:12];
        nz_g = nz_t; rest_nz = nz_u; hi_before = nz_b || nz_m;
      end
      default: begin
        h = bcd_r[11:8]; t = bcd_r[7:4]; o = bcd_r[3:0];
        nz_g = nz_u; rest_nz = 1'b0; hi_before = nz_b || nz_m || nz_t;
      end
    endcase
  end

  assign is_u  = (cmd.grp == nsw_pkg::GRP_UNI);
  assign is_t  = (cmd.grp == nsw_pkg::GRP_THO);
  assign t_one = (h == 4'd0) && (t == 4'd0) && (o == 4'd1);
  // In ordinal mode a lone one thousand drops its "one" unless a higher group came first.
  assign gate  = nz_g && !(op_r && is_t && t_one && !hi_before);
  assign tens7 = {t, 3'b000} + {2'b00, t, 1'b0};
  assign rem7  = tens7 + {3'b000, o};

  always_comb begin
    cur_apply = 1'b0;
    cur_cls   = nsw_pkg::TK_CARD;
    cur_word  = 7'd0;
    unique case (cmd.kind)
      nsw_pkg::KIND_MINUS: begin
        cur_apply = u_r[31];
        cur_cls   = nsw_pkg::TK_MINUS;
      end
      nsw_pkg::KIND_SPEC: begin
        if (is_zero) begin
          cur_apply = 1'b1;
          cur_cls   = op_r ? nsw_pkg::TK_NONE : nsw_pkg::TK_CARD;
        end else if (!is_min && !op_r && is_big) begin
          cur_apply = 1'b1;
          cur_cls   = nsw_pkg::TK_ERROR;
        end else if (!is_min && op_r && is_max) begin
          cur_apply = 1'b1;
          cur_cls   = nsw_pkg::TK_LAST;
        end
      end
      nsw_pkg::KIND_WORD: begin
        unique case (cmd.sub)
          nsw_pkg::SUB_HUNDW: begin
            // Ordinal units group drops a leading "one" before hundred unless a higher group came first.
            cur_apply = words_on && gate && (h != 4'd0) &&
                        !(op_r && is_u && (h == 4'd1) && !hi_before);
            cur_word  = {3'b000, h};
          end
          nsw_pkg::SUB_HUND: begin
            cur_apply = words_on && gate && (h != 4'd0);
            cur_cls   = (op_r && is_u && (t == 4'd0) && (o == 4'd0)) ?
                        nsw_pkg::TK_OHUND : nsw_pkg::TK_HUND;
          end
          nsw_pkg::SUB_TENS: begin
            cur_apply = words_on && gate && (t > 4'd1);
            cur_word  = tens7;
            cur_cls   = (op_r && is_u && (o == 4'd0)) ? nsw_pkg::TK_ORD : nsw_pkg::TK_CARD;
          end
          nsw_pkg::SUB_ONES: begin
            if (t > 4'd1) begin
              cur_apply = words_on && gate && (o != 4'd0);
              cur_word  = {3'b000, o};
            end else begin
              cur_apply = words_on && gate && (rem7 != 7'd0);
              cur_word  = rem7;
            end
            cur_cls = (op_r && is_u) ? nsw_pkg::TK_ORD : nsw_pkg::TK_CARD;
          end
          nsw_pkg::SUB_GROUP: begin
            cur_apply = words_on && nz_g && !is_u;
            unique case (cmd.grp)
              nsw_pkg::GRP_BIL: cur_cls = (op_r && !rest_nz) ? nsw_pkg::TK_OBILL : nsw_pkg::TK_BILL;
              nsw_pkg::GRP_MIL: cur_cls = (op_r && !rest_nz) ? nsw_pkg::TK_OMILL : nsw_pkg::TK_MILL;
              default:          cur_cls = (op_r && !rest_nz) ? nsw_pkg::TK_OTHOU : nsw_pkg::TK_THOU;
            endcase
          end
          default: cur_apply = 1'b0;
        endcase
      end
      default: cur_apply = 1'b0;
    endcase
  end

  // One token waits in the pending stage until the next one, or the end of the
  // item, tells whether it is the last.
  assign out_free = !out_valid_r || out_ready;
  assign push     = (cmd.capture && pend_v_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load || cmd.flush) begin
        pend_v_r <= 1'b0;
      end else if (cmd.capture) begin
        pend_v_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_cls_r  <= cur_cls;
      pend_word_r <= cur_word;
    end
    if (push) begin
      out_cls_r  <= pend_cls_r;
      out_word_r <= pend_word_r;
      out_last_r <= cmd.flush;
    end
  end

  assign stat.apply    = cur_apply;
  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = out_free;

  assign out_valid       = out_valid_r;
  assign out_token_class = out_cls_r;
  assign out_word_value  = out_word_r;
  assign out_last        = out_last_r;

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < nsw_pkg::NSW_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  a_capture_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && pend_v_r |-> out_free)
    else $error("token captured while pending and output stages are full");

  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> pend_v_r && out_free)
    else $error("flush without a pending token or a free output stage");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load) || $past(cmd.conv) |-> bcd_ok)
    else $error("decimal digit out of range after conversion step");

endmodule
